>>> hdl/fcf_pkg.sv
package fcf_pkg;

	localparam int TAPS_DEF        = 256;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_BITS       = 24;
	localparam int FRAC_BITS       = 23;
	localparam int ACC_BITS        = 64;
	localparam int CFG_BITS        = 9;
	localparam int INDEX_BITS      = 8;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

>>> hdl/fir_convolution_filter.sv
// Sample item: the result sums min(tap_count, TAPS) products through the shared
// multiply-accumulate (none when no taps); the next item is taken the cycle after the result
// is registered, so a sample is finished before the next one is accepted.
// Coefficient load: no result. Idle input ignores out_stall; a finished sample waits on it.
// Reset (arst_n low) clears control state; then a clearing pass over all TAPS entries zeroes
// both memories while in_stall stays high. tap_count resets to 1.
module fir_convolution_filter #(
	parameter int TAPS        = fcf_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fcf_pkg::CFG_BITS-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [fcf_pkg::INDEX_BITS-1:0]      coeff_index,
	input  logic signed [fcf_pkg::COEF_BITS-1:0] coeff_value,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic                                block_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       filtered,
	output logic                                saturated,
	output logic                                block_end_res
);

	localparam int AW  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int NW  = $clog2(TAPS + 1);
	localparam int CW  = (NW > fcf_pkg::CFG_BITS) ? NW : fcf_pkg::CFG_BITS;
	localparam int CB  = fcf_pkg::COEF_BITS;
	localparam int PW  = CB + SAMPLE_BITS;
	localparam int AB  = fcf_pkg::ACC_BITS;
	localparam int FB  = fcf_pkg::FRAC_BITS;
	localparam int TOP = FB + SAMPLE_BITS - 1;

	fcf_pkg::state_t st_q, st_d;

	logic [fcf_pkg::CFG_BITS-1:0] tap_q;
	logic [NW-1:0]                n_eff;
	logic [NW-1:0]                t_q;
	logic [AW-1:0]                ptr_q, ptr_nx, pos_q, clr_q, cidx;
	logic                         accept, ld, smp, out_free, issue, fin, t_last;
	logic                         v_s1, v_s2, be_q;

	logic signed [CB-1:0]          coef_mem [TAPS];
	logic signed [SAMPLE_BITS-1:0] hist_mem [TAPS];
	logic signed [CB-1:0]          c_s1;
	logic signed [SAMPLE_BITS-1:0] h_s1;
	logic signed [PW-1:0]          p_s2;
	logic [AB-1:0]                 acc_q, rnd;
	logic [AB-1:TOP]               upper;
	logic                          ovf;
	logic [SAMPLE_BITS-1:0]        res;

	logic                          hist_we, coef_we;
	logic [AW-1:0]                 hist_wa, coef_wa;
	logic [SAMPLE_BITS-1:0]        hist_wd;
	logic [CB-1:0]                 coef_wd;

	logic                          out_valid_q, sat_q, be_res_q;
	logic [SAMPLE_BITS-1:0]        filt_q;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign ld        = accept && (op == fcf_pkg::OP_LOAD);
	assign smp       = accept && (op == fcf_pkg::OP_SAMPLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign n_eff  = (CW'(tap_q) > CW'(TAPS)) ? NW'(TAPS) : NW'(tap_q);
	assign t_last = ((t_q + NW'(1)) == n_eff);
	assign ptr_nx = (ptr_q == AW'(TAPS - 1)) ? '0 : ptr_q + AW'(1);

	always_comb begin
		logic [fcf_pkg::INDEX_BITS-1:0] lv;
		lv = coeff_index;
		for (int k = fcf_pkg::INDEX_BITS - 1; k >= 0; k--) begin
			if (32'(lv) >= (TAPS << k)) begin
				lv = lv - fcf_pkg::INDEX_BITS'(TAPS << k);
			end
		end
		cidx = AW'(lv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fcf_pkg::ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		in_stall = 1'b1;
		issue    = 1'b0;
		fin      = 1'b0;
		unique case (st_q)
			fcf_pkg::ST_CLEAR: begin
				if (clr_q == AW'(TAPS - 1)) st_d = fcf_pkg::ST_IDLE;
			end
			fcf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (smp) st_d = (n_eff == '0) ? fcf_pkg::ST_DONE : fcf_pkg::ST_MAC;
			end
			fcf_pkg::ST_MAC: begin
				issue = 1'b1;
				if (t_last) st_d = fcf_pkg::ST_DRAIN;
			end
			fcf_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) st_d = fcf_pkg::ST_DONE;
			end
			fcf_pkg::ST_DONE: begin
				if (out_free) begin
					fin  = 1'b1;
					st_d = fcf_pkg::ST_IDLE;
				end
			end
			default: st_d = fcf_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q       <= fcf_pkg::CFG_BITS'(1);
			clr_q       <= '0;
			ptr_q       <= '0;
			t_q         <= '0;
			pos_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) tap_q <= cfg_data;
			if (st_q == fcf_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (smp) begin
				ptr_q <= ptr_nx;
				pos_q <= ptr_nx;
				t_q   <= '0;
			end else if (issue) begin
				pos_q <= (pos_q == '0) ? AW'(TAPS - 1) : pos_q - AW'(1);
				t_q   <= t_q + NW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign hist_we = (st_q == fcf_pkg::ST_CLEAR) || smp;
	assign hist_wa = (st_q == fcf_pkg::ST_CLEAR) ? clr_q : ptr_nx;
	assign hist_wd = (st_q == fcf_pkg::ST_CLEAR) ? '0 : sample;
	assign coef_we = (st_q == fcf_pkg::ST_CLEAR) || ld;
	assign coef_wa = (st_q == fcf_pkg::ST_CLEAR) ? clr_q : cidx;
	assign coef_wd = (st_q == fcf_pkg::ST_CLEAR) ? '0 : coeff_value;

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_wa] <= hist_wd;
		h_s1 <= hist_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (coef_we) coef_mem[coef_wa] <= coef_wd;
		c_s1 <= coef_mem[t_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		p_s2 <= c_s1 * h_s1;
		if (smp) begin
			be_q  <= block_end;
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(AB - PW){p_s2[PW-1]}}, p_s2};
		end
	end

	assign rnd   = acc_q + (AB'(1) << (FB - 1));
	assign upper = rnd[AB-1:TOP];
	assign ovf   = !((&upper) || !(|upper));
	assign res   = ovf ? {rnd[AB-1], {(SAMPLE_BITS - 1){!rnd[AB-1]}}} : rnd[TOP:FB];

	always_ff @(posedge clk) begin
		if (fin) begin
			filt_q   <= res;
			sat_q    <= ovf;
			be_res_q <= be_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign filtered      = filt_q;
	assign saturated     = sat_q;
	assign block_end_res = be_res_q;

endmodule

>>> tb/tb_top.sv
module tb_top;

	localparam int TAPS        = fcf_pkg::TAPS_DEF;
	localparam int SB          = fcf_pkg::SAMPLE_BITS_DEF;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [SB-1:0] filtered;
		logic          saturated;
		logic          block_end_res;
	} fir_result_t;

	logic                                 clk;
	logic                                 arst_n        = 1'b0;
	logic                                 cfg_valid     = 1'b0;
	logic                                 cfg_ready;
	logic [fcf_pkg::CFG_BITS-1:0]         cfg_data      = '0;
	logic                                 in_valid      = 1'b0;
	logic                                 in_stall;
	logic                                 op            = fcf_pkg::OP_LOAD;
	logic [fcf_pkg::INDEX_BITS-1:0]       coeff_index   = '0;
	logic signed [fcf_pkg::COEF_BITS-1:0] coeff_value   = '0;
	logic signed [SB-1:0]                 sample        = '0;
	logic                                 block_end     = 1'b0;
	logic                                 out_valid;
	logic                                 out_stall     = 1'b0;
	logic signed [SB-1:0]                 filtered;
	logic                                 saturated;
	logic                                 block_end_res;

	logic signed [fcf_pkg::COEF_BITS-1:0] tap_coef [TAPS];
	logic signed [SB-1:0]                 delay_line [TAPS];
	logic [fcf_pkg::INDEX_BITS-1:0]       newest_slot;
	logic [fcf_pkg::CFG_BITS-1:0]         taps_in_use;
	fir_result_t                          predicted_outputs [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_request   = 0;
	int error_count    = 0;
	int load_count     = 0;
	int sample_count   = 0;
	int checked_count  = 0;
	int clip_count     = 0;

	fir_convolution_filter i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic fir_result_t filter_sample(logic signed [SB-1:0] x, logic be);
		logic signed [fcf_pkg::ACC_BITS-1:0] acc;
		logic signed [fcf_pkg::ACC_BITS-1:0] rounded;
		logic [fcf_pkg::INDEX_BITS-1:0]      pos;
		int                                  n;
		int                                  t;
		fir_result_t                         res;
		newest_slot = newest_slot + 1'b1;
		delay_line[newest_slot] = x;
		n = (taps_in_use > TAPS) ? TAPS : taps_in_use;
		acc = '0;
		pos = newest_slot;
		for (t = 0; t < n; t++) begin
			acc = acc + $signed(tap_coef[t]) * $signed(delay_line[pos]);
			pos = pos - 1'b1;
		end
		rounded = (acc + (64'sd1 <<< (fcf_pkg::FRAC_BITS - 1))) >>> fcf_pkg::FRAC_BITS;
		res.saturated = 1'b1;
		if (rounded > 64'sd8388607) begin
			res.filtered = 24'h7FFFFF;
		end else if (rounded < -64'sd8388608) begin
			res.filtered = 24'h800000;
		end else begin
			res.filtered = rounded[SB-1:0];
			res.saturated = 1'b0;
		end
		res.block_end_res = be;
		return res;
	endfunction

	function automatic logic [23:0] random_word24();
		int small_val;
		case ($urandom_range(7))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: begin
				small_val = $urandom_range(15) - 8;
				return small_val[23:0];
			end
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		$display("ERROR: %s at result %0d: got %0d, want %0d", what, checked_count, got, want);
	endtask

	task automatic send_item(logic op_i, logic [fcf_pkg::INDEX_BITS-1:0] idx,
			logic [fcf_pkg::COEF_BITS-1:0] cval, logic [SB-1:0] smp, logic be);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= op_i;
		coeff_index <= idx;
		coeff_value <= cval;
		sample      <= smp;
		block_end   <= be;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op_i == fcf_pkg::OP_LOAD) begin
			tap_coef[idx] = cval;
			load_count++;
		end else begin
			predicted_outputs.push_back(filter_sample(smp, be));
			sample_count++;
		end
	endtask

	task automatic drain_pipeline(int tail);
		in_valid <= 1'b0;
		while (predicted_outputs.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_tap_count(logic [fcf_pkg::CFG_BITS-1:0] value);
		drain_pipeline(8);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid   <= 1'b0;
		taps_in_use = value;
	endtask

	task automatic send_random_item(int span);
		logic [fcf_pkg::INDEX_BITS-1:0] idx;
		if ($urandom_range(3) == 0) begin
			if ($urandom_range(3) == 0)
				idx = 8'($urandom);
			else
				idx = 8'($urandom_range(span - 1));
			send_item(fcf_pkg::OP_LOAD, idx, random_word24(), random_word24(),
				1'($urandom));
		end else begin
			send_item(fcf_pkg::OP_SAMPLE, 8'($urandom), random_word24(), random_word24(),
				1'($urandom));
		end
	endtask

	task automatic run_random_phase(logic [fcf_pkg::CFG_BITS-1:0] taps, int count,
			int send_pct, int recv_pct);
		int span;
		write_tap_count(taps);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		span = (taps == 0) ? 1 : ((taps > TAPS) ? TAPS : taps);
		repeat (count) send_random_item(span);
	endtask

	task automatic test_reset_state();
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h7FFFFF, 1'b0);
		send_item(fcf_pkg::OP_SAMPLE, 8'hFF, 24'hFFFFFF, 24'h800000, 1'b1);
	endtask

	task automatic test_single_tap_extremes();
		send_item(fcf_pkg::OP_LOAD, 8'h00, 24'h800000, 24'h000000, 1'b0);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h800000, 1'b1);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h7FFFFF, 1'b0);
		send_item(fcf_pkg::OP_LOAD, 8'h00, 24'h7FFFFF, 24'hFFFFFF, 1'b1);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h800000, 1'b0);
	endtask

	task automatic test_rounding();
		send_item(fcf_pkg::OP_LOAD, 8'h00, 24'h400000, 24'h000000, 1'b0);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h000001, 1'b0);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'hFFFFFF, 1'b1);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h000003, 1'b0);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'hFFFFFD, 1'b1);
	endtask

	task automatic test_ignored_fields();
		send_item(fcf_pkg::OP_LOAD, 8'hFF, 24'h123456, 24'h7FFFFF, 1'b1);
		send_item(fcf_pkg::OP_SAMPLE, 8'hAA, 24'h5A5A5A, 24'h0F0F0F, 1'b1);
	endtask

	task automatic test_tap_count_limits();
		send_item(fcf_pkg::OP_LOAD, 8'h01, 24'h800000, 24'h000000, 1'b0);
		write_tap_count(9'd2);
		send_item(fcf_pkg::OP_LOAD, 8'h00, 24'h800000, 24'h000000, 1'b0);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h7FFFFF, 1'b0);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h7FFFFF, 1'b1);
		write_tap_count(9'd0);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h7FFFFF, 1'b1);
		write_tap_count(9'd511);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h800000, 1'b0);
		write_tap_count(9'd256);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h654321, 1'b1);
		write_tap_count(9'd1);
		send_item(fcf_pkg::OP_SAMPLE, 8'h00, 24'h000000, 24'h800000, 1'b0);
	endtask

	task automatic test_no_idling();
		run_random_phase(9'd8, 250, 0, 0);
	endtask

	task automatic test_sender_gaps();
		run_random_phase(9'($urandom_range(32, 1)), 250, 56, 0);
	endtask

	task automatic test_receiver_stalls();
		run_random_phase(9'd3, 250, 0, 56);
	endtask

	task automatic test_both_idle();
		run_random_phase(9'd16, 250, 8, 8);
	endtask

	task automatic test_long_filters();
		int i;
		write_tap_count(9'd256);
		send_idle_pct  = 8;
		recv_stall_pct = 8;
		for (i = 0; i < TAPS; i++)
			send_item(fcf_pkg::OP_LOAD, 8'(i), random_word24(), random_word24(),
				1'($urandom));
		repeat (40) send_random_item(TAPS);
		run_random_phase(9'd300, 20, 8, 8);
		run_random_phase(9'd0, 30, 8, 8);
	endtask

	task automatic test_output_backpressure();
		run_random_phase(9'd4, 0, 0, 0);
		hold_request = 400;
		repeat (60) send_random_item(4);
	endtask

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin : result_checker
		fir_result_t want;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (predicted_outputs.size() == 0) begin
					report_mismatch("unexpected result", filtered, 0);
				end else begin
					want = predicted_outputs.pop_front();
					if (filtered !== want.filtered)
						report_mismatch("filtered", filtered, $signed(want.filtered));
					if (saturated !== want.saturated)
						report_mismatch("saturated", saturated, want.saturated);
					if (block_end_res !== want.block_end_res)
						report_mismatch("block_end_res", block_end_res,
							want.block_end_res);
					if (want.saturated)
						clip_count++;
				end
				checked_count++;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < TAPS; i++) begin
			tap_coef[i]   = '0;
			delay_line[i] = '0;
		end
		newest_slot = '0;
		taps_in_use = 9'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_single_tap_extremes();
		test_rounding();
		test_ignored_fields();
		test_tap_count_limits();
		test_no_idling();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_long_filters();
		test_output_backpressure();
		drain_pipeline(TAPS + 8);
		$display("Ran %0d coefficient loads and %0d samples over tap counts 0 to 511,",
			load_count, sample_count);
		$display("checking %0d results (%0d clipped) under gaps, stalls and a long hold-off.",
			checked_count, clip_count);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
